@@ rtl/core/spi_pkg.sv @@
// Shared types, widths and constants of the spline pose interpolator.
// Used by spi_ctrl, spi_dp and the top level; depends on nothing.
`default_nettype none

package spi_pkg;

  // fixed-point format of positions, quaternions and matrix elements
  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;
  localparam int T_W       = 16;

  // window and result shape
  localparam int NUM_PTS  = 4;
  localparam int NUM_COMP = 7;
  localparam int NUM_PROD = 10;
  localparam int NUM_ELEM = 9;
  localparam int NUM_TRANS = 3;
  localparam int NUM_RES  = NUM_ELEM + NUM_TRANS;
  localparam int QUAT_BASE = 3;
  localparam int IN_W     = (NUM_COMP + 1) * DATA_W;
  localparam int OUT_W    = NUM_RES * DATA_W;

  // internal widths
  localparam int WGT_W  = 53;               // basis numerator, 2^48 scale
  localparam int WQ_W   = 33;               // Q2.30 weight
  localparam int MUL_W  = 34;
  localparam int ACC_W  = 52;
  localparam int COMP_W = 20;               // blended component
  localparam int SQ_W   = 40;               // quaternion products
  localparam int S_W    = 42;               // squared norm
  localparam int NUM_W  = 43;               // matrix numerator
  localparam int QB     = FRAC_BITS + 2;    // quotient bits, offset form
  localparam int REM_W  = FRAC_BITS + 43;

  // sequencing
  localparam int MAC_ISSUES = NUM_COMP * NUM_PTS;
  localparam int CNT_W      = $clog2(MAC_ISSUES + 1);
  localparam int IDX_W      = 4;
  localparam int TPOW_LAST  = 3;
  localparam int RCP_LAST   = NUM_PTS;
  localparam int DIV_LAST   = QB + 1;
  localparam int ELEM_LAST  = NUM_ELEM - 1;

  // arithmetic constants
  localparam logic signed [WGT_W-1:0] ONE_W  = 53'sh1_0000_0000_0000;
  localparam logic signed [WGT_W-1:0] CR_RND = WGT_W'(1) <<< 18;
  localparam logic signed [WGT_W-1:0] BS_RND = WGT_W'(3) <<< 18;
  localparam logic signed [MUL_W-1:0] RECIP3 = 34'sh0_AAAA_AAAB;
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< 29;
  localparam logic signed [QB:0]      K_OFF  = (QB + 1)'(2 ** FRAC_BITS);
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(2 ** FRAC_BITS);
  localparam logic signed [COMP_W-1:0] SAT_HI = COMP_W'(32767);
  localparam logic signed [COMP_W-1:0] SAT_LO = COMP_W'(-32768);

  // quaternion product slots
  localparam int PQ_XX = 0;
  localparam int PQ_YY = 1;
  localparam int PQ_ZZ = 2;
  localparam int PQ_WW = 3;
  localparam int PQ_XY = 4;
  localparam int PQ_ZW = 5;
  localparam int PQ_XZ = 6;
  localparam int PQ_YW = 7;
  localparam int PQ_YZ = 8;
  localparam int PQ_XW = 9;

  // matrix element slots
  localparam int ROT_00 = 0;
  localparam int ROT_01 = 1;
  localparam int ROT_02 = 2;
  localparam int ROT_10 = 3;
  localparam int ROT_11 = 4;
  localparam int ROT_12 = 5;
  localparam int ROT_20 = 6;
  localparam int ROT_21 = 7;
  localparam int ROT_22 = 8;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_TPOW = 9'b000000010,
    S_WGT  = 9'b000000100,
    S_RCP  = 9'b000001000,
    S_MAC  = 9'b000010000,
    S_PROD = 9'b000100000,
    S_SUM  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } spi_state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_PUSH, CMD_LOAD_T, CMD_TSQ, CMD_TCUBE, CMD_WGT, CMD_RCP,
    CMD_MAC, CMD_PROD, CMD_SUM, CMD_DIVLD, CMD_DIVSTEP, CMD_DIVST, CMD_EMIT
  } spi_op_e;

  typedef struct packed {
    spi_op_e          op;
    logic [1:0]       widx;   // control point
    logic [2:0]       cidx;   // component
    logic [IDX_W-1:0] idx;    // product or matrix element
  } spi_cmd_t;

  // first factor of each quaternion product, 0 x .. 3 w
  function automatic logic [1:0] pair_a(input logic [IDX_W-1:0] k);
    logic [1:0] r;
    case (k)
      IDX_W'(PQ_YY), IDX_W'(PQ_YW), IDX_W'(PQ_YZ): r = 2'd1;
      IDX_W'(PQ_ZZ), IDX_W'(PQ_ZW):                r = 2'd2;
      IDX_W'(PQ_WW):                               r = 2'd3;
      default:                                     r = 2'd0;
    endcase
    return r;
  endfunction

  // second factor of each quaternion product
  function automatic logic [1:0] pair_b(input logic [IDX_W-1:0] k);
    logic [1:0] r;
    case (k)
      IDX_W'(PQ_YY), IDX_W'(PQ_XY):                              r = 2'd1;
      IDX_W'(PQ_ZZ), IDX_W'(PQ_XZ), IDX_W'(PQ_YZ):               r = 2'd2;
      IDX_W'(PQ_WW), IDX_W'(PQ_ZW), IDX_W'(PQ_YW), IDX_W'(PQ_XW): r = 2'd3;
      default:                                                   r = 2'd0;
    endcase
    return r;
  endfunction

  // clamp a blended component to 16 bits
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [COMP_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7fff;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/spi_ctrl.sv @@
// Sequencer of the spline pose interpolator: input/output handshake and
// the command stream to spi_dp. Depends on spi_pkg.
`default_nettype none

module spi_ctrl import spi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spi_cmd_t cmd_o
);

  spi_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] elem_q, elem_d;
  logic           out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    cmd_o       = '{op: CMD_NONE, widx: '0, cidx: '0, idx: '0};
    state_d     = state_q;
    cnt_d       = cnt_q;
    elem_d      = elem_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i) begin
            cmd_o.op = CMD_LOAD_T;
            state_d  = S_TPOW;
            cnt_d    = '0;
          end else begin
            cmd_o.op = CMD_PUSH;
          end
        end
      end
      S_TPOW: begin
        if (cnt_q == CNT_W'(0)) begin
          cmd_o.op = CMD_TSQ;
        end else if (cnt_q == CNT_W'(2)) begin
          cmd_o.op = CMD_TCUBE;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TPOW_LAST)) begin
          state_d = S_WGT;
          cnt_d   = '0;
        end
      end
      S_WGT: begin
        cmd_o.op = CMD_WGT;
        state_d  = S_RCP;
        cnt_d    = '0;
      end
      S_RCP: begin
        if (cnt_q < CNT_W'(RCP_LAST)) begin
          cmd_o.op   = CMD_RCP;
          cmd_o.widx = cnt_q[1:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(RCP_LAST)) begin
          state_d = S_MAC;
          cnt_d   = '0;
        end
      end
      S_MAC: begin
        if (cnt_q < CNT_W'(MAC_ISSUES)) begin
          cmd_o.op   = CMD_MAC;
          cmd_o.widx = cnt_q[1:0];
          cmd_o.cidx = 3'(cnt_q >> 2);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAC_ISSUES)) begin
          state_d = S_PROD;
          cnt_d   = '0;
        end
      end
      S_PROD: begin
        if (cnt_q < CNT_W'(NUM_PROD)) begin
          cmd_o.op  = CMD_PROD;
          cmd_o.idx = IDX_W'(cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_PROD)) begin
          state_d = S_SUM;
          cnt_d   = '0;
        end
      end
      S_SUM: begin
        cmd_o.op = CMD_SUM;
        state_d  = S_DIV;
        cnt_d    = '0;
        elem_d   = '0;
      end
      S_DIV: begin
        cmd_o.idx = elem_q;
        if (cnt_q == CNT_W'(0)) begin
          cmd_o.op = CMD_DIVLD;
        end else if (cnt_q == CNT_W'(DIV_LAST)) begin
          cmd_o.op = CMD_DIVST;
        end else begin
          cmd_o.op = CMD_DIVSTEP;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_LAST)) begin
          cnt_d = '0;
          if (elem_q == IDX_W'(ELEM_LAST)) begin
            state_d = S_EMIT;
          end else begin
            elem_d = elem_q + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = CMD_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      elem_q      <= elem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == CMD_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken word");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == CMD_EMIT) |=> (out_valid_q && state_q == S_IDLE))
    else $error("loaded result not presented");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= CNT_W'(DIV_LAST) && elem_q <= IDX_W'(ELEM_LAST)))
    else $error("divider sequencing out of range");

  a_eval_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_op_i) |=> (state_q == S_TPOW && cnt_q == '0))
    else $error("evaluate word did not start the sequence");

endmodule

`default_nettype wire

@@ rtl/core/spi_dp.sv @@
// Datapath of the spline pose interpolator: control point window, shared
// multiplier, accumulator and serial divider. Depends on spi_pkg.
`default_nettype none

module spi_dp import spi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spi_cmd_t        cmd_i,
  input  logic [IN_W-1:0] in_data_i,   // pos_x .. quat_w, param_t
  input  logic            cfg_we_i,
  input  logic            cfg_data_i,
  output logic [OUT_W-1:0] res_o
);

  logic                       spline_mode_q;
  logic signed [DATA_W-1:0]   win_q [NUM_PTS][NUM_COMP];
  spi_cmd_t                   cmd_q;

  logic [T_W-1:0]             t_q;
  logic [2*T_W-1:0]           t2_q;
  logic [3*T_W-1:0]           t3_q;
  logic signed [WGT_W-1:0]    t1e, t2e, t3e;
  logic signed [WGT_W-1:0]    w_q [NUM_PTS];
  logic signed [WGT_W-1:0]    w_d [NUM_PTS];
  logic signed [WGT_W-1:0]    w_bs, w_cr;
  logic [31:0]                u_sel;
  logic signed [WQ_W-1:0]     wq_q [NUM_PTS];
  logic signed [WQ_W-1:0]     wq_nx;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [2*MUL_W-1:0]  prod_q;
  logic [2:0]                 qa, qb;

  logic signed [ACC_W-1:0]    acc_q, acc_nx, acc_rnd;
  logic signed [COMP_W-1:0]   comp_q [NUM_COMP];
  logic signed [SQ_W-1:0]     pq_q [NUM_PROD];
  logic signed [S_W-1:0]      s_q, s_d;
  logic signed [NUM_W-1:0]    pe [NUM_PROD];
  logic signed [NUM_W-1:0]    sx, num;
  logic signed [REM_W+1:0]    np;
  logic [REM_W-1:0]           rem_q, dsh_q;
  logic [QB-1:0]              q_q;
  logic                       div_ge;
  logic signed [QB:0]         rot_v;
  logic signed [DATA_W-1:0]   rot_q [NUM_ELEM];
  logic signed [DATA_W-1:0]   res_q [NUM_RES];

  // basis numerators at 2^48 scale
  always_comb begin
    t1e = $signed(WGT_W'({t_q, 32'b0}));
    t2e = $signed(WGT_W'({t2_q, 16'b0}));
    t3e = $signed(WGT_W'(t3_q));
    if (spline_mode_q) begin
      w_d[0] = -t3e + 3 * t2e - 3 * t1e + ONE_W;
      w_d[1] = 3 * t3e - 6 * t2e + 4 * ONE_W;
      w_d[2] = -3 * t3e + 3 * t2e + 3 * t1e + ONE_W;
      w_d[3] = t3e;
    end else begin
      w_d[0] = -t3e + 2 * t2e - t1e;
      w_d[1] = 3 * t3e - 5 * t2e + 2 * ONE_W;
      w_d[2] = -3 * t3e + 4 * t2e + t1e;
      w_d[3] = t3e - t2e;
    end
  end

  // weight rounding: shift for catmull-rom, reciprocal of three for b-spline
  always_comb begin
    w_bs  = w_q[cmd_i.widx] + BS_RND;
    u_sel = w_bs[50:19];
    w_cr  = w_q[cmd_q.widx] + CR_RND;
    if (spline_mode_q) begin
      wq_nx = $signed({2'b00, prod_q[63:33]});
    end else begin
      wq_nx = w_cr[51:19];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    qa    = 3'(QUAT_BASE) + {1'b0, pair_a(cmd_i.idx)};
    qb    = 3'(QUAT_BASE) + {1'b0, pair_b(cmd_i.idx)};
    case (cmd_i.op)
      CMD_TSQ: begin
        mul_a = $signed(MUL_W'(t_q));
        mul_b = $signed(MUL_W'(t_q));
      end
      CMD_TCUBE: begin
        mul_a = $signed(MUL_W'(t2_q));
        mul_b = $signed(MUL_W'(t_q));
      end
      CMD_RCP: begin
        mul_a = $signed(MUL_W'(u_sel));
        mul_b = RECIP3;
      end
      CMD_MAC: begin
        mul_a = MUL_W'(wq_q[cmd_i.widx]);
        mul_b = MUL_W'(win_q[cmd_i.widx][cmd_i.cidx]);
      end
      CMD_PROD: begin
        mul_a = MUL_W'(comp_q[qa]);
        mul_b = MUL_W'(comp_q[qb]);
      end
      default: begin
      end
    endcase
  end

  // accumulate and round to the component grid
  always_comb begin
    acc_nx  = ((cmd_q.widx == 2'd0) ? '0 : acc_q) + ACC_W'(prod_q);
    acc_rnd = acc_nx + ACC_RND;
  end

  // squared norm and matrix numerator for the current element
  always_comb begin
    for (int k = 0; k < NUM_PROD; k++) begin
      pe[k] = NUM_W'(pq_q[k]);
    end
    s_d = S_W'(pq_q[PQ_XX]) + S_W'(pq_q[PQ_YY]) + S_W'(pq_q[PQ_ZZ]) + S_W'(pq_q[PQ_WW]);
    sx  = NUM_W'(s_q);
    case (cmd_i.idx)
      IDX_W'(ROT_00): num = sx - ((pe[PQ_YY] + pe[PQ_ZZ]) <<< 1);
      IDX_W'(ROT_01): num = (pe[PQ_XY] - pe[PQ_ZW]) <<< 1;
      IDX_W'(ROT_02): num = (pe[PQ_XZ] + pe[PQ_YW]) <<< 1;
      IDX_W'(ROT_10): num = (pe[PQ_XY] + pe[PQ_ZW]) <<< 1;
      IDX_W'(ROT_11): num = sx - ((pe[PQ_XX] + pe[PQ_ZZ]) <<< 1);
      IDX_W'(ROT_12): num = (pe[PQ_YZ] - pe[PQ_XW]) <<< 1;
      IDX_W'(ROT_20): num = (pe[PQ_XZ] - pe[PQ_YW]) <<< 1;
      IDX_W'(ROT_21): num = (pe[PQ_YZ] + pe[PQ_XW]) <<< 1;
      IDX_W'(ROT_22): num = sx - ((pe[PQ_XX] + pe[PQ_YY]) <<< 1);
      default:        num = '0;
    endcase
    // offset dividend keeps the rounded quotient non-negative
    np = ((REM_W + 2)'(num) <<< (FRAC_BITS + 1)) + (REM_W + 2)'(s_q)
         + ((REM_W + 2)'(s_q) <<< (FRAC_BITS + 1));
    div_ge = (rem_q >= dsh_q);
    rot_v  = $signed({1'b0, q_q}) - K_OFF;
  end

  // output word packing, rot_00 lowest
  always_comb begin
    for (int e = 0; e < NUM_RES; e++) begin
      res_o[e*DATA_W +: DATA_W] = res_q[e];
    end
  end

  // mode register, window and command pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spline_mode_q <= 1'b0;
      cmd_q         <= '{op: CMD_NONE, widx: '0, cidx: '0, idx: '0};
      for (int i = 0; i < NUM_PTS; i++) begin
        for (int j = 0; j < NUM_COMP; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      cmd_q <= cmd_i;
      if (cfg_we_i) begin
        spline_mode_q <= cfg_data_i;
      end
      if (cmd_i.op == CMD_PUSH) begin
        for (int i = 0; i < NUM_PTS - 1; i++) begin
          for (int j = 0; j < NUM_COMP; j++) begin
            win_q[i][j] <= win_q[i+1][j];
          end
        end
        for (int j = 0; j < NUM_COMP; j++) begin
          win_q[NUM_PTS-1][j] <= $signed(in_data_i[j*DATA_W +: DATA_W]);
        end
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      CMD_LOAD_T: t_q <= in_data_i[NUM_COMP*DATA_W +: T_W];
      CMD_WGT: begin
        for (int i = 0; i < NUM_PTS; i++) begin
          w_q[i] <= w_d[i];
        end
      end
      CMD_SUM: s_q <= s_d;
      CMD_DIVLD: begin
        rem_q <= np[REM_W-1:0];
        dsh_q <= REM_W'(s_q) << QB;
        q_q   <= '0;
      end
      CMD_DIVSTEP: begin
        if (div_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        q_q   <= {q_q[QB-2:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      CMD_DIVST: rot_q[cmd_i.idx] <= DATA_W'(rot_v);
      CMD_EMIT: begin
        for (int e = 0; e < NUM_ELEM; e++) begin
          if (s_q == '0) begin
            res_q[e] <= (e == ROT_00 || e == ROT_11 || e == ROT_22) ? ONE_Q : '0;
          end else begin
            res_q[e] <= rot_q[e];
          end
        end
        for (int j = 0; j < NUM_TRANS; j++) begin
          res_q[NUM_ELEM+j] <= sat16(comp_q[j]);
        end
      end
      default: begin
      end
    endcase
    // products issued by the command now held in cmd_q
    case (cmd_q.op)
      CMD_TSQ:   t2_q <= prod_q[2*T_W-1:0];
      CMD_TCUBE: t3_q <= prod_q[3*T_W-1:0];
      CMD_RCP:   wq_q[cmd_q.widx] <= wq_nx;
      CMD_MAC: begin
        acc_q <= acc_nx;
        if (cmd_q.widx == 2'd3) begin
          comp_q[cmd_q.cidx] <= acc_rnd[49:30];
        end
      end
      CMD_PROD:  pq_q[cmd_q.idx] <= prod_q[SQ_W-1:0];
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/spline_pose_interpolator.sv @@
// Spline pose interpolator: four-point cubic spline over position and
// quaternion, giving a rotation matrix and translation per evaluate word.
// Channels: input stream (s_axis_*), result stream (m_axis_*), a one-bit
// mode write channel (cfg_*: 0 catmull-rom, 1 uniform b-spline).
// A push word (tuser 0) shifts a control point into the window and
// gives no result; the next word is taken the cycle after.
// An evaluate word (tuser 1) takes param_t and produces one result word
// after acceptance: weight and blend work on the single shared 34x34
// multiplier, then nine divisions on the serial divider, one quotient bit
// per cycle, then the load of the output register. No new word is taken
// until the result is loaded.
// The result sits in an output register; while the receiver stalls the
// block still takes push words, and a following evaluate waits at its end
// until the output register is free.
// Reset clears the window to zero, the mode to catmull-rom and drops any
// pending result. Write the mode only while the block is idle.
// Depends on spi_pkg, spi_ctrl and spi_dp.
`default_nettype none

module spline_pose_interpolator import spi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z,
                                           // quat_w, param_t
  input  logic             s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // rot_00 .. rot_22 row by row, trans_x,
                                           // trans_y, trans_z
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i      // spline_mode
);

  spi_cmd_t cmd;
  logic     cfg_we;

  // mode writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // sequencer
  spi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  // arithmetic
  spi_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .res_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ verif/tb_spline_pose_interpolator.sv @@
// Self-checking testbench for spline_pose_interpolator: directed and random
// push/evaluate streams, both spline modes, random idling and stalls.
// Depends on spi_pkg and the top level of the block.
`default_nettype none

module tb_spline_pose_interpolator;
  import spi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam logic MODE_CATMULL = 1'b0;
  localparam logic MODE_BSPLINE = 1'b1;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic signed [15:0] qw, qz, qy, qx, pz, py, px;
  } ctrl_point_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_data_i = 1'b0;

  spline_pose_interpolator u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i
  );

  // predictor state
  longint     win[4][7];
  logic       mode_q = MODE_CATMULL;
  logic [OUT_W-1:0] pose_q[$];
  int         err_count = 0;
  longint     cycle_count = 0;
  int         hold_off = 0;    // long receiver stall, in cycles
  int         burst_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint rnd_div(longint n, longint d);
    return floor_div(2 * n + d, 2 * d);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // blended pose for parameter t over the current window
  function automatic logic [OUT_W-1:0] pose_at(logic [15:0] t);
    longint tt, one, t3, t2, t1, den, acc, x, y, z, w, s;
    longint wt[4], wq[4], c[7], num[9];
    logic [OUT_W-1:0] r;
    tt = t; one = longint'(1) << 48;
    t3 = tt * tt * tt; t2 = tt * tt * 65536; t1 = tt << 32;
    if (mode_q == MODE_CATMULL) begin
      wt[0] = -t3 + 2 * t2 - t1;
      wt[1] = 3 * t3 - 5 * t2 + 2 * one;
      wt[2] = -3 * t3 + 4 * t2 + t1;
      wt[3] = t3 - t2;
      den = longint'(2) << 18;
    end else begin
      wt[0] = -t3 + 3 * t2 - 3 * t1 + one;
      wt[1] = 3 * t3 - 6 * t2 + 4 * one;
      wt[2] = -3 * t3 + 3 * t2 + 3 * t1 + one;
      wt[3] = t3;
      den = longint'(6) << 18;
    end
    for (int i = 0; i < 4; i++) wq[i] = rnd_div(wt[i], den);
    for (int j = 0; j < 7; j++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) acc += wq[i] * win[i][j];
      c[j] = rnd_div(acc, longint'(1) << 30);
    end
    x = c[3]; y = c[4]; z = c[5]; w = c[6];
    s = x * x + y * y + z * z + w * w;
    r = '0;
    if (s == 0) begin
      for (int i = 0; i < 9; i++)
        r[16*i +: 16] = (i % 4 == 0) ? clamp16(longint'(1) << FRAC_BITS) : 16'h0;
    end else begin
      num[0] = s - 2 * (y * y + z * z);
      num[1] = 2 * (x * y - z * w);
      num[2] = 2 * (x * z + y * w);
      num[3] = 2 * (x * y + z * w);
      num[4] = s - 2 * (x * x + z * z);
      num[5] = 2 * (y * z - x * w);
      num[6] = 2 * (x * z - y * w);
      num[7] = 2 * (y * z + x * w);
      num[8] = s - 2 * (x * x + y * y);
      for (int i = 0; i < 9; i++)
        r[16*i +: 16] = clamp16(rnd_div(num[i] * (longint'(1) << FRAC_BITS), s));
    end
    for (int j = 0; j < 3; j++) r[16*(9+j) +: 16] = clamp16(c[j]);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // send one word, with burst/gap idling on the sender side
  // the word stays offered until the next call, a gap or an idle bus
  task automatic send_word(logic op, ctrl_point_t pt, logic [15:0] t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {t, pt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_PUSH) begin
      for (int i = 0; i < 3; i++) win[i] = win[i + 1];
      win[3] = '{pt.px, pt.py, pt.pz, pt.qx, pt.qy, pt.qz, pt.qw};
    end else begin
      pose_q.push_back(pose_at(t));
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  function automatic ctrl_point_t rand_point(int kind);
    ctrl_point_t p;
    p = 112'({$urandom, $urandom, $urandom, $urandom});
    if (kind == 1) p = {7{16'sh7fff}};
    if (kind == 2) p = {7{16'sh8000}};
    if (kind == 3) begin   // moderate values, realistic poses
      p.px = 16'($urandom_range(0, 16383) - 8192);
      p.py = 16'($urandom_range(0, 16383) - 8192);
      p.pz = 16'($urandom_range(0, 16383) - 8192);
      p.qx = 16'($urandom_range(0, 8191) - 4096);
      p.qy = 16'($urandom_range(0, 8191) - 4096);
      p.qz = 16'($urandom_range(0, 8191) - 4096);
      p.qw = 16'($urandom_range(0, 8191) - 4096);
    end
    return p;
  endfunction

  // directed: empty window, extremes, t extremes, zero norm
  task automatic test_directed;
    send_word(OP_EVAL, '0, 16'h0000);
    send_word(OP_EVAL, rand_point(0), 16'hffff);
    send_word(OP_PUSH, rand_point(1), 16'hffff);
    send_word(OP_EVAL, '0, 16'h8000);
    send_word(OP_PUSH, rand_point(2), 16'h0);
    send_word(OP_PUSH, rand_point(1), 16'h0);
    send_word(OP_PUSH, rand_point(2), 16'h0);
    send_word(OP_EVAL, '0, 16'h0000);
    send_word(OP_EVAL, '0, 16'hffff);
    send_word(OP_EVAL, '0, 16'h4000);
    for (int i = 0; i < 4; i++) send_word(OP_PUSH, ctrl_point_t'('0), 16'h0);
    send_word(OP_EVAL, '0, 16'h1234);
    for (int i = 0; i < 4; i++) send_word(OP_PUSH, rand_point(3), 16'h0);
    send_word(OP_EVAL, '0, 16'h0001);
    send_word(OP_EVAL, '0, 16'hc000);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_word(OP_EVAL, rand_point(0), 16'($urandom));
      else
        send_word(OP_PUSH, rand_point($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) :
                  $urandom_range(0, 1) * 3), 16'($urandom));
    end
  endtask

  // receiver held off while pushes and evaluates keep coming
  task automatic test_backpressure;
    hold_off = 600;
    for (int i = 0; i < 12; i++) send_word(i % 4 == 3 ? OP_EVAL : OP_PUSH, rand_point(3),
                                           16'($urandom));
    drain();
  endtask

  initial begin
    foreach (win[i, j]) win[i][j] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_mode(MODE_BSPLINE);
    test_directed();
    test_random(300);
    test_backpressure();
    write_mode(MODE_CATMULL);
    test_random(300);
    drain();
    write_mode(MODE_BSPLINE);
    test_random(300);
    write_mode(MODE_CATMULL);
    test_random(250);
    drain();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (cycle_count % 1024 < 256) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pose_q.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        exp_w = pose_q.pop_front();
        for (int f = 0; f < NUM_RES; f++)
          if (m_axis_tdata[16*f +: 16] !== exp_w[16*f +: 16])
            report_mismatch($sformatf("field %0d got %h expected %h", f,
                                      m_axis_tdata[16*f +: 16], exp_w[16*f +: 16]));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

`default_nettype wire
